>>> hw/rtl/grid_3x3_weighted_smoothing_top_defines.svh
`ifndef GRID_3X3_WEIGHTED_SMOOTHING_TOP_DEFINES_SVH
`define GRID_3X3_WEIGHTED_SMOOTHING_TOP_DEFINES_SVH

// same-cycle check on aclk, disabled while aresetn is low
`define G3S_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle check on aclk, disabled while aresetn is low
`define G3S_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/g3s_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package g3s_pkg;

    // field and datapath widths
    localparam int SAMPLE_W    = 32;
    localparam int VSUM_W      = 35;   // top + 4*mid + bottom
    localparam int SUM_W       = 38;   // full 3x3 weighted sum
    localparam int ABS_W       = 35;   // |sum| / 4
    localparam int YH_W        = 17;
    localparam int YL_W        = 18;
    localparam int QH_W        = 14;
    localparam int REM_W       = 4;
    localparam int X_W         = REM_W + YL_W;
    localparam int QL_W        = 18;
    localparam int Q_W         = QH_W + QL_W;
    localparam int IDX_W       = 6;
    localparam int GS_W        = 7;
    localparam int OUT_TDATA_W = 48;
    localparam int PAD_W       = OUT_TDATA_W - SAMPLE_W - 2 * IDX_W;

    // configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_ADDR_W-1:0] CFG_GRID_SIZE   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_STRIDE_MODE = 2'd1;

    localparam logic [GS_W-1:0] GRID_SIZE_RESET = 7'd64;
    localparam logic            STRIDE_RESET    = 1'b0;
    localparam int              GRID_MIN        = 3;

    // divide by 9 in two narrow reciprocal steps: q = (x * M) >> k, M = 2^k / 9 + 1
    localparam int HI_MULT_W = 18;
    localparam int HI_SHIFT  = 21;
    localparam logic [HI_MULT_W-1:0] HI_MULT = 18'((2 ** HI_SHIFT) / 9 + 1);
    localparam int LO_MULT_W = 23;
    localparam int LO_SHIFT  = 26;
    localparam logic [LO_MULT_W-1:0] LO_MULT = 23'((2 ** LO_SHIFT) / 9 + 1);

    // position info carried along with each result
    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             last;
    } res_meta_t;

endpackage

`default_nettype wire

>>> hw/rtl/grid_3x3_weighted_smoothing_top.sv
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tdata: sample
//  m_      | out | m_tvalid/m_tready  | m_tdata: smoothed, out_row, out_col; m_tlast: frame_last
//  cfg_    | in  | cfg_wr_en          | cfg_wr_addr, cfg_wr_data (grid_size, stride_mode)
//
//  one word per cycle sustained while m_tready is high; a word that yields a result
//  passes through eight registered stages in order: input stage, vertical sum, 3x3 sum,
//  abs, upper divide-by-9 step, remainder, lower divide-by-9 step, sign
//  the line memory is read one cycle ahead at the next column address
//  reset clears counters, config and stage valids; the line memory is not cleared
//  s_tready is low in reset, else drops only when all eight stages hold data and
//  m_tready is low
`timescale 1ns / 1ps
`default_nettype none
`include "grid_3x3_weighted_smoothing_top_defines.svh"

module grid_3x3_weighted_smoothing_top #(
    parameter int MAX_DIM = 64
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [g3s_pkg::CFG_ADDR_W-1:0]        cfg_wr_addr,
    input  wire logic [g3s_pkg::CFG_DATA_W-1:0]        cfg_wr_data,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    input  wire logic [g3s_pkg::SAMPLE_W-1:0]          s_tdata,   // [31:0] sample
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic [g3s_pkg::OUT_TDATA_W-1:0]            m_tdata,   // [31:0] smoothed,
                                                                  // [37:32] out_row,
                                                                  // [43:38] out_col
    output logic                                       m_tlast    // frame_last
);

    localparam int CW   = $clog2(MAX_DIM);
    localparam int NW   = ($clog2(MAX_DIM + 1) > g3s_pkg::GS_W) ?
                          $clog2(MAX_DIM + 1) : g3s_pkg::GS_W;
    localparam int PW   = (CW > g3s_pkg::IDX_W) ? CW : g3s_pkg::IDX_W + 1;
    localparam int NSTG = 8;
    localparam int LW   = 2 * g3s_pkg::SAMPLE_W;

    // configuration registers
    logic [g3s_pkg::GS_W-1:0] grid_size_reg;
    logic                     stride_reg;
    logic                     cfg_hit;

    assign cfg_hit = cfg_wr_en && ((cfg_wr_addr == g3s_pkg::CFG_GRID_SIZE) ||
                                   (cfg_wr_addr == g3s_pkg::CFG_STRIDE_MODE));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_size_reg <= g3s_pkg::GRID_SIZE_RESET;
            stride_reg    <= g3s_pkg::STRIDE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_wr_addr)
                g3s_pkg::CFG_GRID_SIZE:   grid_size_reg <= cfg_wr_data;
                g3s_pkg::CFG_STRIDE_MODE: stride_reg    <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // effective grid size and end positions
    logic [NW-1:0] gs_ext, n_eff, n_m1, n_m2, lastpos;
    logic [CW-1:0] row_reg, col_reg, row_next, col_next;
    logic [NW-1:0] r_ext, c_ext;
    logic          at_row_end, at_frame_end;

    assign gs_ext  = NW'(grid_size_reg);
    assign n_eff   = (gs_ext < NW'(g3s_pkg::GRID_MIN)) ? NW'(g3s_pkg::GRID_MIN) :
                     ((gs_ext > NW'(MAX_DIM)) ? NW'(MAX_DIM) : gs_ext);
    assign n_m1    = n_eff - NW'(1);
    assign n_m2    = n_eff - NW'(2);
    assign lastpos = n_m1[0] ? n_m2 : n_m1;
    assign r_ext   = NW'(row_reg);
    assign c_ext   = NW'(col_reg);
    assign at_row_end   = (c_ext == n_m1);
    assign at_frame_end = at_row_end && (r_ext == n_m1);

    // stage handshake chain
    logic [NSTG:1] vld_reg;
    logic [NSTG:1] adv;
    logic          s_fire;

    always_comb begin
        adv[NSTG] = !vld_reg[NSTG] || m_tready;
        for (int i = NSTG - 1; i >= 1; i--) begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign s_tready = adv[1] && aresetn;
    assign s_fire   = s_tvalid && s_tready;

    // raster position counters
    always_comb begin
        row_next = row_reg;
        col_next = col_reg;
        if (cfg_hit) begin
            row_next = '0;
            col_next = '0;
        end else if (s_fire) begin
            if (at_row_end) begin
                col_next = '0;
                row_next = at_frame_end ? '0 : row_reg + CW'(1);
            end else begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
            col_reg <= '0;
        end else begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // line memory: each entry holds {row above, two rows above} of one column
    logic [LW-1:0] line_mem [MAX_DIM];
    logic [LW-1:0] line_rd_reg;

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            line_mem[col_reg] <= {s_tdata, line_rd_reg[LW-1:g3s_pkg::SAMPLE_W]};
        end
        line_rd_reg <= line_mem[col_next];
    end

    // window placement and output indices for the incoming word
    logic [PW-1:0]            r_m2, c_m2;
    logic                     emit0;
    logic                     s1_emit_reg;
    g3s_pkg::res_meta_t       meta0;

    assign r_m2  = PW'(row_reg) - PW'(2);
    assign c_m2  = PW'(col_reg) - PW'(2);
    assign emit0 = (row_reg >= CW'(2)) && (col_reg >= CW'(2)) &&
                   (!stride_reg || (!row_reg[0] && !col_reg[0]));

    always_comb begin
        if (stride_reg) begin
            meta0.row  = r_m2[g3s_pkg::IDX_W:1];
            meta0.col  = c_m2[g3s_pkg::IDX_W:1];
            meta0.last = (r_ext == lastpos) && (c_ext == lastpos);
        end else begin
            meta0.row  = r_m2[g3s_pkg::IDX_W-1:0];
            meta0.col  = c_m2[g3s_pkg::IDX_W-1:0];
            meta0.last = at_frame_end;
        end
    end

    // stage valids; words without a result drop out after the window shift
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (adv[1]) vld_reg[1] <= s_tvalid;
            if (adv[2]) vld_reg[2] <= vld_reg[1] && s1_emit_reg;
            for (int i = 3; i <= NSTG; i++) begin
                if (adv[i]) vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // result position travels with the data
    g3s_pkg::res_meta_t meta_reg [1:NSTG];

    always_ff @(posedge aclk) begin
        if (adv[1]) meta_reg[1] <= meta0;
        for (int i = 2; i <= NSTG; i++) begin
            if (adv[i]) meta_reg[i] <= meta_reg[i-1];
        end
    end

    // stage 1: input word with its column from the line memory
    logic signed [g3s_pkg::SAMPLE_W-1:0] s1_s_reg, s1_top_reg, s1_mid_reg;

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            s1_s_reg    <= s_tdata;
            s1_top_reg  <= line_rd_reg[g3s_pkg::SAMPLE_W-1:0];
            s1_mid_reg  <= line_rd_reg[LW-1:g3s_pkg::SAMPLE_W];
            s1_emit_reg <= emit0;
        end
    end

    // stage 2: vertical 1-4-1 sum and column window shift
    logic signed [g3s_pkg::VSUM_W-1:0] vsum;
    logic signed [g3s_pkg::VSUM_W-1:0] win1_reg, win2_reg;
    logic signed [g3s_pkg::VSUM_W-1:0] s2_v_reg, s2_w1_reg, s2_w2_reg;

    assign vsum = g3s_pkg::VSUM_W'(s1_top_reg) + (g3s_pkg::VSUM_W'(s1_mid_reg) <<< 2) +
                  g3s_pkg::VSUM_W'(s1_s_reg);

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            s2_v_reg  <= vsum;
            s2_w1_reg <= win1_reg;
            s2_w2_reg <= win2_reg;
        end
        if (adv[2] && vld_reg[1]) begin
            win2_reg <= win1_reg;
            win1_reg <= vsum;
        end
    end

    // stage 3: horizontal 1-4-1 sum
    logic signed [g3s_pkg::SUM_W-1:0] s3_sum_reg;

    always_ff @(posedge aclk) begin
        if (adv[3]) begin
            s3_sum_reg <= g3s_pkg::SUM_W'(s2_w2_reg) + (g3s_pkg::SUM_W'(s2_w1_reg) <<< 2) +
                          g3s_pkg::SUM_W'(s2_v_reg);
        end
    end

    // stage 4: magnitude divided by 4
    logic [g3s_pkg::SUM_W-1:0] sum_abs;
    logic [g3s_pkg::ABS_W-1:0] s4_y_reg;
    logic                      s4_neg_reg;

    assign sum_abs = s3_sum_reg[g3s_pkg::SUM_W-1] ? -s3_sum_reg : s3_sum_reg;

    always_ff @(posedge aclk) begin
        if (adv[4]) begin
            s4_neg_reg <= s3_sum_reg[g3s_pkg::SUM_W-1];
            s4_y_reg   <= sum_abs[g3s_pkg::ABS_W+1:2];
        end
    end

    // stage 5: upper bits divided by 9
    localparam int HP_W = g3s_pkg::YH_W + g3s_pkg::HI_MULT_W;
    logic [g3s_pkg::YH_W-1:0] yh;
    logic [HP_W-1:0]          hi_prod;
    logic [g3s_pkg::YH_W-1:0] s5_yh_reg;
    logic [g3s_pkg::YL_W-1:0] s5_yl_reg;
    logic [g3s_pkg::QH_W-1:0] s5_qh_reg;
    logic                     s5_neg_reg;

    assign yh      = s4_y_reg[g3s_pkg::ABS_W-1:g3s_pkg::YL_W];
    assign hi_prod = HP_W'(yh) * HP_W'(g3s_pkg::HI_MULT);

    always_ff @(posedge aclk) begin
        if (adv[5]) begin
            s5_yh_reg  <= yh;
            s5_yl_reg  <= s4_y_reg[g3s_pkg::YL_W-1:0];
            s5_qh_reg  <= hi_prod[g3s_pkg::HI_SHIFT +: g3s_pkg::QH_W];
            s5_neg_reg <= s4_neg_reg;
        end
    end

    // stage 6: remainder of the upper part joined to the lower bits
    logic [g3s_pkg::YH_W-1:0] hi_rem;
    logic [g3s_pkg::X_W-1:0]  s6_x_reg;
    logic [g3s_pkg::QH_W-1:0] s6_qh_reg;
    logic                     s6_neg_reg;

    assign hi_rem = s5_yh_reg - (g3s_pkg::YH_W'(s5_qh_reg) << 3) - g3s_pkg::YH_W'(s5_qh_reg);

    always_ff @(posedge aclk) begin
        if (adv[6]) begin
            s6_x_reg   <= {hi_rem[g3s_pkg::REM_W-1:0], s5_yl_reg};
            s6_qh_reg  <= s5_qh_reg;
            s6_neg_reg <= s5_neg_reg;
        end
    end

    // stage 7: lower part divided by 9
    localparam int LP_W = g3s_pkg::X_W + g3s_pkg::LO_MULT_W;
    logic [LP_W-1:0]          lo_prod;
    logic [g3s_pkg::QL_W-1:0] s7_ql_reg;
    logic [g3s_pkg::QH_W-1:0] s7_qh_reg;
    logic                     s7_neg_reg;

    assign lo_prod = LP_W'(s6_x_reg) * LP_W'(g3s_pkg::LO_MULT);

    always_ff @(posedge aclk) begin
        if (adv[7]) begin
            s7_ql_reg  <= lo_prod[g3s_pkg::LO_SHIFT +: g3s_pkg::QL_W];
            s7_qh_reg  <= s6_qh_reg;
            s7_neg_reg <= s6_neg_reg;
        end
    end

    // stage 8: quotient with sign restored, output register
    logic [g3s_pkg::Q_W-1:0]      quot;
    logic [g3s_pkg::SAMPLE_W-1:0] s8_res_reg;

    assign quot = {s7_qh_reg, s7_ql_reg};

    always_ff @(posedge aclk) begin
        if (adv[8]) begin
            s8_res_reg <= s7_neg_reg ? -quot : quot;
        end
    end

    assign m_tvalid = vld_reg[NSTG];
    assign m_tlast  = meta_reg[NSTG].last;
    assign m_tdata  = {{g3s_pkg::PAD_W{1'b0}}, meta_reg[NSTG].col, meta_reg[NSTG].row,
                       s8_res_reg};

    // checks
    `G3S_ASSERT_SAME(a_cnt_range, 1'b1, (r_ext < n_eff) && (c_ext < n_eff),
        "position counters outside the grid")
    `G3S_ASSERT_SAME(a_ready_free, !vld_reg[1], s_tready,
        "input stalled with an empty first stage")
    `G3S_ASSERT_NEXT(a_frame_wrap, s_fire && at_frame_end && !cfg_hit,
        (row_reg == '0) && (col_reg == '0), "counters did not wrap at frame end")
    `G3S_ASSERT_SAME(a_last_diag, m_tvalid && m_tlast,
        meta_reg[NSTG].row == meta_reg[NSTG].col, "frame end result off the diagonal")

endmodule

`default_nettype wire
